@@ hw/rtl/dvw_pkg.sv @@
// Shared types, constants and table functions for the date check and weekday pipeline.
// Used by every module under hw/rtl; depends on nothing else.
package dvw_pkg;

    typedef struct packed {
        logic [7:0]  day_of_month;
        logic [3:0]  month_code;
        logic [15:0] year_value;
    } dvw_req_t;

    typedef struct packed {
        logic       date_valid;
        logic [2:0] week_day;
        logic       leap_year;
    } dvw_rsp_t;

    // floor(x / 100) equals (x * DIV100_MUL) >> DIV100_SHIFT for every 16-bit x.
    localparam logic [16:0] DIV100_MUL   = 17'd83887;
    localparam int unsigned DIV100_SHIFT = 23;
    localparam int unsigned PROD_W       = 33;
    localparam int unsigned QUOT_W       = PROD_W - DIV100_SHIFT;
    localparam int unsigned SUM_W        = 17;
    localparam int unsigned FOLD_W       = 6;

    localparam logic [3:0] MONTH_JAN  = 4'd1;
    localparam logic [3:0] MONTH_FEB  = 4'd2;
    localparam logic [3:0] MONTH_MAR  = 4'd3;
    localparam logic [3:0] MONTH_APR  = 4'd4;
    localparam logic [3:0] MONTH_FIVE = 4'd5;
    localparam logic [3:0] MONTH_JUN  = 4'd6;
    localparam logic [3:0] MONTH_JUL  = 4'd7;
    localparam logic [3:0] MONTH_AUG  = 4'd8;
    localparam logic [3:0] MONTH_SEP  = 4'd9;
    localparam logic [3:0] MONTH_OCT  = 4'd10;
    localparam logic [3:0] MONTH_NOV  = 4'd11;
    localparam logic [3:0] MONTH_DEC  = 4'd12;

    localparam logic [6:0] HUNDRED   = 7'd100;
    localparam logic [3:0] MOD_SEVEN = 4'd7;

    typedef struct packed {
        logic [7:0]        day_of_month;
        logic [3:0]        month_code;
        logic [15:0]       year_value;
        logic [15:0]       adj_year;
        logic [PROD_W-1:0] prod_year;
        logic [PROD_W-1:0] prod_adj;
    } dvw_s1_t;

    typedef struct packed {
        logic             date_ok;
        logic             leap;
        logic [SUM_W-1:0] day_sum;
    } dvw_s2_t;

    typedef struct packed {
        logic              date_ok;
        logic              leap;
        logic [FOLD_W-1:0] fold;
    } dvw_s3_t;

    // Sakamoto month offsets; codes outside 1..12 never reach a valid result.
    function automatic logic [2:0] month_offset(input logic [3:0] month);
        logic [2:0] off;
        unique case (month)
            MONTH_FEB:  off = 3'd3;
            MONTH_MAR:  off = 3'd2;
            MONTH_APR:  off = 3'd5;
            MONTH_FIVE: off = 3'd0;
            MONTH_JUN:  off = 3'd3;
            MONTH_JUL:  off = 3'd5;
            MONTH_AUG:  off = 3'd1;
            MONTH_SEP:  off = 3'd4;
            MONTH_OCT:  off = 3'd6;
            MONTH_NOV:  off = 3'd2;
            MONTH_DEC:  off = 3'd4;
            default:    off = 3'd0;
        endcase
        return off;
    endfunction

    // Days in the month; zero marks an illegal month code.
    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            MONTH_JAN, MONTH_MAR, MONTH_FIVE, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: len = 5'd31;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default:   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

@@ hw/rtl/dvw_front.sv @@
// First pipeline stage: captures the date, forms the weekday year and the
// reciprocal products for division by 100. Depends on dvw_pkg.
module dvw_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               req_valid,
    input  dvw_pkg::dvw_req_t  req,
    output logic               s1_valid,
    output dvw_pkg::dvw_s1_t   s1
);

    logic             valid_reg;
    dvw_pkg::dvw_s1_t s1_reg;
    dvw_pkg::dvw_s1_t s1_next;
    logic [15:0]      adj_year;

    // January and February count as months of the previous year, wrapping at zero.
    assign adj_year = (req.month_code < dvw_pkg::MONTH_MAR) ? (req.year_value - 16'd1)
                                                             : req.year_value;

    always_comb
    begin
        s1_next.day_of_month = req.day_of_month;
        s1_next.month_code   = req.month_code;
        s1_next.year_value   = req.year_value;
        s1_next.adj_year     = adj_year;
        s1_next.prod_year    = dvw_pkg::PROD_W'(req.year_value * dvw_pkg::DIV100_MUL);
        s1_next.prod_adj     = dvw_pkg::PROD_W'(adj_year * dvw_pkg::DIV100_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1       = s1_reg;

endmodule

@@ hw/rtl/dvw_combine.sv @@
// Second pipeline stage: leap year test, day range check and the Sakamoto sum.
// Depends on dvw_pkg.
module dvw_combine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              s1_valid,
    input  dvw_pkg::dvw_s1_t  s1,
    output logic              s2_valid,
    output dvw_pkg::dvw_s2_t  s2
);

    logic                             valid_reg;
    dvw_pkg::dvw_s2_t                 s2_reg;
    dvw_pkg::dvw_s2_t                 s2_next;
    logic [dvw_pkg::QUOT_W-1:0]       quot_year;
    logic [dvw_pkg::QUOT_W-1:0]       quot_adj;
    logic [15:0]                      rem_year;
    logic                             leap;
    logic [4:0]                       limit;

    assign quot_year = s1.prod_year[dvw_pkg::PROD_W-1:dvw_pkg::DIV100_SHIFT];
    assign quot_adj  = s1.prod_adj[dvw_pkg::PROD_W-1:dvw_pkg::DIV100_SHIFT];
    assign rem_year  = s1.year_value - 16'(quot_year * dvw_pkg::HUNDRED);

    // A multiple of 400 is a multiple of 100 whose hundreds count is a multiple of 4.
    assign leap  = (s1.year_value[1:0] == 2'd0) &&
                   ((rem_year != 16'd0) || (quot_year[1:0] == 2'd0));
    assign limit = dvw_pkg::month_length(s1.month_code, leap);

    always_comb
    begin
        s2_next.leap    = leap;
        s2_next.date_ok = (s1.day_of_month != 8'd0) && (limit != 5'd0) &&
                          (s1.day_of_month <= {3'd0, limit});
        s2_next.day_sum = {1'b0, s1.adj_year}
                        + {3'd0, s1.adj_year[15:2]}
                        - dvw_pkg::SUM_W'(quot_adj)
                        + dvw_pkg::SUM_W'(quot_adj[dvw_pkg::QUOT_W-1:2])
                        + dvw_pkg::SUM_W'(dvw_pkg::month_offset(s1.month_code))
                        + dvw_pkg::SUM_W'(s1.day_of_month);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2_valid = valid_reg;
    assign s2       = s2_reg;

endmodule

@@ hw/rtl/dvw_mod7.sv @@
// Third and fourth pipeline stages: reduce the weekday sum modulo 7 and
// register the result transaction. Depends on dvw_pkg.
module dvw_mod7 (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              s2_valid,
    input  dvw_pkg::dvw_s2_t  s2,
    output logic              rsp_valid,
    output dvw_pkg::dvw_rsp_t rsp
);

    logic              s3_valid_reg;
    dvw_pkg::dvw_s3_t  s3_reg;
    dvw_pkg::dvw_s3_t  s3_next;
    logic              rsp_valid_reg;
    dvw_pkg::dvw_rsp_t rsp_reg;
    dvw_pkg::dvw_rsp_t rsp_next;
    logic [3:0]        fold2;
    logic [3:0]        residue;

    // Since 8 is 1 modulo 7, summing the octal digits keeps the residue.
    always_comb
    begin
        s3_next.date_ok = s2.date_ok;
        s3_next.leap    = s2.leap;
        s3_next.fold    = dvw_pkg::FOLD_W'(s2.day_sum[2:0])
                        + dvw_pkg::FOLD_W'(s2.day_sum[5:3])
                        + dvw_pkg::FOLD_W'(s2.day_sum[8:6])
                        + dvw_pkg::FOLD_W'(s2.day_sum[11:9])
                        + dvw_pkg::FOLD_W'(s2.day_sum[14:12])
                        + dvw_pkg::FOLD_W'(s2.day_sum[16:15]);
    end

    assign fold2   = {1'b0, s3_reg.fold[2:0]} + {1'b0, s3_reg.fold[5:3]};
    assign residue = (fold2 >= dvw_pkg::MOD_SEVEN) ? (fold2 - dvw_pkg::MOD_SEVEN) : fold2;

    always_comb
    begin
        rsp_next.date_valid = s3_reg.date_ok;
        rsp_next.leap_year  = s3_reg.leap;
        rsp_next.week_day   = s3_reg.date_ok ? (residue[2:0] + 3'd1) : 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg  <= s2_valid;
            rsp_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg  <= s3_next;
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ hw/rtl/date_validate_weekday.sv @@
// Date check and day of week: validates day, month and 16-bit year and gives the
// Sakamoto weekday (1=Sunday..7=Saturday, 0 for an illegal date) and the leap flag.
// Depends on dvw_pkg, dvw_front, dvw_combine and dvw_mod7.
//
// The block is a four-stage pipeline of front, combine, fold and result registers: a date
// accepted at a clock edge passes through them in order, and a new date can be accepted
// in every cycle that the response side does not stall. The depth is set by the
// division by 100 (a reciprocal multiply, then the leap test and weekday sum) and the
// two-step modulo-7 fold. When the response side stalls a waiting result, every
// stage holds and the request side stalls with it; nothing is lost or repeated.
module date_validate_weekday (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  dvw_pkg::dvw_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output dvw_pkg::dvw_rsp_t rsp_data
);

    logic             en;
    logic             s1_valid;
    logic             s2_valid;
    dvw_pkg::dvw_s1_t s1;
    dvw_pkg::dvw_s2_t s2;

    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;

    dvw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req_valid (req_valid),
        .req       (req_data),
        .s1_valid  (s1_valid),
        .s1        (s1)
    );

    dvw_combine u_combine (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .s1_valid (s1_valid),
        .s1       (s1),
        .s2_valid (s2_valid),
        .s2       (s2)
    );

    dvw_mod7 u_mod7 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .s2_valid  (s2_valid),
        .s2        (s2),
        .rsp_valid (rsp_valid),
        .rsp       (rsp_data)
    );

endmodule
